// ----- rtl/kbdsc_pkg.sv -----
// ----------------------------------------------------------------------------
// kbdsc_pkg
// Shared types, scan code constants and the printable key table for the
// set 1 scan code event decoder.
// ----------------------------------------------------------------------------
package kbdsc_pkg;

	// number of keys in the printable table and how many of them are searched
	localparam int KEY_COUNT   = 47;
	localparam int TABLE_KEYS  = 47;
	localparam int LOOKUP_KEYS = (TABLE_KEYS < KEY_COUNT) ? TABLE_KEYS : KEY_COUNT;

	localparam logic [7:0] PREFIX_BYTE = 8'hE0;
	localparam logic [7:0] EXT_HIGH    = 8'hE0;

	// complete codes (prefix in the high byte)
	localparam logic [15:0] CODE_LSHIFT_MAKE  = 16'h002A;
	localparam logic [15:0] CODE_RSHIFT_MAKE  = 16'h0036;
	localparam logic [15:0] CODE_LSHIFT_BREAK = 16'h00AA;
	localparam logic [15:0] CODE_RSHIFT_BREAK = 16'h00B6;
	localparam logic [15:0] CODE_CAPS_MAKE    = 16'h003A;
	localparam logic [15:0] CODE_CTRL_MAKE    = 16'h001D;
	localparam logic [15:0] CODE_CTRL_BREAK   = 16'h009D;
	localparam logic [15:0] CODE_ALT_MAKE     = 16'h0038;
	localparam logic [15:0] CODE_RALT_MAKE    = 16'hE038;
	localparam logic [15:0] CODE_ALT_BREAK    = 16'h00B8;
	localparam logic [15:0] CODE_RALT_BREAK   = 16'hE0B8;
	localparam logic [15:0] CODE_ESC_BREAK    = 16'h0081;
	localparam logic [15:0] CODE_SPACE        = 16'h0039;
	localparam logic [15:0] CODE_BACKSPACE    = 16'h000E;
	localparam logic [15:0] CODE_ENTER        = 16'h001C;
	localparam logic [15:0] CODE_TAB          = 16'h000F;

	// modifier mask bits
	localparam int MOD_SHIFT_BIT = 0;
	localparam int MOD_CAPS_BIT  = 1;
	localparam int MOD_CTRL_BIT  = 2;
	localparam int MOD_ALT_BIT   = 3;

	typedef enum logic [2:0] {
		EV_NONE        = 3'd0,
		EV_CHAR        = 3'd1,
		EV_SPACE       = 3'd2,
		EV_BACKSPACE   = 3'd3,
		EV_WORD_DELETE = 3'd4,
		EV_ENTER       = 3'd5,
		EV_TAB         = 3'd6,
		EV_EXIT        = 3'd7
	} event_t;

	typedef struct packed {
		logic [7:0] code;
		logic [6:0] lower;
		logic [6:0] upper;
	} key_entry_t;

	// decoder state carried between words
	typedef struct packed {
		logic       prefix;
		logic [3:0] mods;
	} dec_state_t;

	// one result word
	typedef struct packed {
		event_t     ev;
		logic [6:0] ch;
		logic [3:0] mods;
	} result_t;

	localparam key_entry_t KEY_TABLE [KEY_COUNT] = '{
		'{8'h29, 7'h60, 7'h7E}, '{8'h02, 7'h31, 7'h21}, '{8'h03, 7'h32, 7'h40},
		'{8'h04, 7'h33, 7'h23}, '{8'h05, 7'h34, 7'h24}, '{8'h06, 7'h35, 7'h25},
		'{8'h07, 7'h36, 7'h5E}, '{8'h08, 7'h37, 7'h26}, '{8'h09, 7'h38, 7'h2A},
		'{8'h0A, 7'h39, 7'h28}, '{8'h0B, 7'h30, 7'h29}, '{8'h0C, 7'h2D, 7'h5F},
		'{8'h0D, 7'h3D, 7'h2B},
		'{8'h10, 7'h71, 7'h51}, '{8'h11, 7'h77, 7'h57}, '{8'h12, 7'h65, 7'h45},
		'{8'h13, 7'h72, 7'h52}, '{8'h14, 7'h74, 7'h54}, '{8'h15, 7'h79, 7'h59},
		'{8'h16, 7'h75, 7'h55}, '{8'h17, 7'h69, 7'h49}, '{8'h18, 7'h6F, 7'h4F},
		'{8'h19, 7'h70, 7'h50}, '{8'h1A, 7'h5B, 7'h7B}, '{8'h1B, 7'h5D, 7'h7D},
		'{8'h2B, 7'h5C, 7'h7C},
		'{8'h1E, 7'h61, 7'h41}, '{8'h1F, 7'h73, 7'h53}, '{8'h20, 7'h64, 7'h44},
		'{8'h21, 7'h66, 7'h46}, '{8'h22, 7'h67, 7'h47}, '{8'h23, 7'h68, 7'h48},
		'{8'h24, 7'h6A, 7'h4A}, '{8'h25, 7'h6B, 7'h4B}, '{8'h26, 7'h6C, 7'h4C},
		'{8'h27, 7'h3B, 7'h3A}, '{8'h28, 7'h27, 7'h22},
		'{8'h2C, 7'h7A, 7'h5A}, '{8'h2D, 7'h78, 7'h58}, '{8'h2E, 7'h63, 7'h43},
		'{8'h2F, 7'h76, 7'h56}, '{8'h30, 7'h62, 7'h42}, '{8'h31, 7'h6E, 7'h4E},
		'{8'h32, 7'h6D, 7'h4D}, '{8'h33, 7'h2C, 7'h3C}, '{8'h34, 7'h2E, 7'h3E},
		'{8'h35, 7'h2F, 7'h3F}
	};

endpackage

// ----- rtl/kbdsc_key_lut.sv -----
// ----------------------------------------------------------------------------
// kbdsc_key_lut
// Printable key lookup: parallel compare of a code against the key table.
// ----------------------------------------------------------------------------
module kbdsc_key_lut (
	input  logic [15:0] code,
	input  logic        upper,
	output logic        hit,
	output logic [6:0]  ch
);
	import kbdsc_pkg::*;

	logic match;

	// table codes are unique, so or-ing the matches is a clean select
	always_comb begin
		hit = 1'b0;
		ch  = '0;
		for (int i = 0; i < LOOKUP_KEYS; i++) begin
			match = (code[15:8] == 8'h00) && (code[7:0] == KEY_TABLE[i].code);
			hit   = hit | match;
			if (match) begin
				ch = ch | (upper ? KEY_TABLE[i].upper : KEY_TABLE[i].lower);
			end
		end
	end

endmodule

// ----- rtl/kbdsc_decode.sv -----
// ----------------------------------------------------------------------------
// kbdsc_decode
// Single-word decode: prefix assembly, modifier update and event select.
// ----------------------------------------------------------------------------
module kbdsc_decode (
	input  logic [7:0]              rx_byte,
	input  logic                    rx_error,
	input  kbdsc_pkg::dec_state_t   cur,
	output kbdsc_pkg::dec_state_t   nxt,
	output kbdsc_pkg::result_t      res
);
	import kbdsc_pkg::*;

	logic [15:0] code;
	logic [3:0]  mods_new;
	logic        upper;
	logic        lut_hit;
	logic [6:0]  lut_ch;

	assign code  = cur.prefix ? {EXT_HIGH, rx_byte} : {8'h00, rx_byte};
	assign upper = mods_new[MOD_CAPS_BIT] ^ mods_new[MOD_SHIFT_BIT];

	kbdsc_key_lut u_lut (
		.code  (code),
		.upper (upper),
		.hit   (lut_hit),
		.ch    (lut_ch)
	);

	always_comb begin
		mods_new = cur.mods;
		if (code == CODE_LSHIFT_MAKE || code == CODE_RSHIFT_MAKE)
			mods_new[MOD_SHIFT_BIT] = 1'b1;
		else if (code == CODE_LSHIFT_BREAK || code == CODE_RSHIFT_BREAK)
			mods_new[MOD_SHIFT_BIT] = 1'b0;
		else if (code == CODE_CAPS_MAKE)
			mods_new[MOD_CAPS_BIT] = ~cur.mods[MOD_CAPS_BIT];
		else if (code == CODE_CTRL_MAKE)
			mods_new[MOD_CTRL_BIT] = 1'b1;
		else if (code == CODE_CTRL_BREAK)
			mods_new[MOD_CTRL_BIT] = 1'b0;
		else if (code == CODE_ALT_MAKE || code == CODE_RALT_MAKE)
			mods_new[MOD_ALT_BIT] = 1'b1;
		else if (code == CODE_ALT_BREAK || code == CODE_RALT_BREAK)
			mods_new[MOD_ALT_BIT] = 1'b0;
	end

	always_comb begin
		nxt     = cur;
		res.ev  = EV_NONE;
		res.ch  = '0;
		res.mods = cur.mods;
		if (!rx_error) begin
			if (rx_byte == PREFIX_BYTE) begin
				nxt.prefix = 1'b1;
			end else begin
				nxt.prefix = 1'b0;
				nxt.mods   = mods_new;
				res.mods   = mods_new;
				if ((mods_new[MOD_CTRL_BIT] | mods_new[MOD_ALT_BIT])
						&& code == CODE_BACKSPACE)
					res.ev = EV_WORD_DELETE;
				else if (code == CODE_ESC_BREAK)
					res.ev = EV_EXIT;
				else if (code == CODE_SPACE)
					res.ev = EV_SPACE;
				else if (code == CODE_BACKSPACE)
					res.ev = EV_BACKSPACE;
				else if (code == CODE_ENTER)
					res.ev = EV_ENTER;
				else if (code == CODE_TAB)
					res.ev = EV_TAB;
				else if (lut_hit) begin
					res.ev = EV_CHAR;
					res.ch = lut_ch;
				end
			end
		end
	end

endmodule

// ----- rtl/keyboard_scancode_event_decoder.sv -----
// ----------------------------------------------------------------------------
// keyboard_scancode_event_decoder
// Turns set 1 scan code bytes into key events with modifier tracking.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------
//  in      | in_valid / in_ready  | rx_byte[7:0], rx_error
//  out     | out_valid/ out_ready | event_code[2:0], char_code[6:0],
//          |                      | modifiers[3:0]
//
//  one word in, one word out; a word passes the input register, then the result
//  register, and one word can enter per cycle while in_ready is high
//  prefix and modifier state update when a word moves from the input register
//  into the result register, so back to back words see each other's effects
//  reset clears the prefix flag, the modifier mask and both valid flags
//  a stalled output holds the result register; the input register then holds
//  one more word and in_ready drops only when both are full
//
module keyboard_scancode_event_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic       rx_error,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] event_code,
	output logic [6:0] char_code,
	output logic [3:0] modifiers
);
	import kbdsc_pkg::*;

	// input register
	logic       valid_s1;
	logic [7:0] rx_byte_s1;
	logic       rx_error_s1;

	// decoder state (prefix pending and modifier mask)
	dec_state_t state_q;
	dec_state_t state_nxt;

	// result register
	logic       valid_s2;
	result_t    res_s2;
	result_t    res_nxt;

	logic       load_s2;
	logic       move_s1;

	// result register frees up when empty or being taken this cycle
	assign load_s2  = !valid_s2 || out_ready;
	assign move_s1  = valid_s1 && load_s2;
	assign in_ready = !valid_s1 || load_s2;

	kbdsc_decode u_decode (
		.rx_byte  (rx_byte_s1),
		.rx_error (rx_error_s1),
		.cur      (state_q),
		.nxt      (state_nxt),
		.res      (res_nxt)
	);

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rx_byte_s1  <= rx_byte;
			rx_error_s1 <= rx_error;
		end
	end

	// state advances only when a word is consumed by the decoder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (move_s1) begin
			state_q <= state_nxt;
		end
	end

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid  = valid_s2;
	assign event_code = res_s2.ev;
	assign char_code  = res_s2.ch;
	assign modifiers  = res_s2.mods;

endmodule

// ----- dv/keyboard_scancode_event_decoder_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyboard_scancode_event_decoder_test
// Drives set 1 scan code words into the decoder and checks every result
// word against a cycle-free decode of the same stream: event, character and
// modifier mask. A directed opening covers the special keys, modifiers,
// prefix handling and error words; a long random stream of mostly
// well-formed key sequences follows, under three idling patterns.
// ----------------------------------------------------------------------------
module keyboard_scancode_event_decoder_test;
	import kbdsc_pkg::*;

	// one scan code word waiting to be sent
	typedef struct {
		logic [7:0] scan;
		logic       err;
		logic       drain;  // hold this word back until all results are in
	} scan_word_t;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_WORDS   = 1700;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] rx_byte = 8'h00;
	logic       rx_error = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [2:0] event_code;
	logic [6:0] char_code;
	logic [3:0] modifiers;

	scan_word_t scan_words [$];
	result_t    expected_results [$];

	// decoder state as the checker sees it
	logic       prefix_held = 1'b0;
	logic [3:0] mod_mask = 4'h0;

	int words_sent = 0;
	int mismatches = 0;
	int quiet_cycles = 0;
	int send_idle_pct = 25;
	int take_idle_pct = 73;

	logic [7:0] modifier_scans [9] = '{8'h2A, 8'h36, 8'hAA, 8'hB6, 8'h3A,
		8'h1D, 8'h9D, 8'h38, 8'hB8};
	logic [7:0] special_scans [5] = '{8'h39, 8'h0E, 8'h1C, 8'h0F, 8'h81};

	keyboard_scancode_event_decoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.rx_byte    (rx_byte),
		.rx_error   (rx_error),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.event_code (event_code),
		.char_code  (char_code),
		.modifiers  (modifiers)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// printable keys: {lower, upper} as 8-bit chars, zero when the code is no key
	function automatic logic [15:0] key_chars(input logic [15:0] code);
		case (code)
			16'h0029: key_chars = {8'h60, "~"};
			16'h0002: key_chars = {"1", "!"};  16'h0003: key_chars = {"2", "@"};
			16'h0004: key_chars = {"3", "#"};  16'h0005: key_chars = {"4", "$"};
			16'h0006: key_chars = {"5", "%"};  16'h0007: key_chars = {"6", "^"};
			16'h0008: key_chars = {"7", "&"};  16'h0009: key_chars = {"8", "*"};
			16'h000A: key_chars = {"9", "("};  16'h000B: key_chars = {"0", ")"};
			16'h000C: key_chars = {"-", "_"};  16'h000D: key_chars = {"=", "+"};
			16'h0010: key_chars = {"q", "Q"};  16'h0011: key_chars = {"w", "W"};
			16'h0012: key_chars = {"e", "E"};  16'h0013: key_chars = {"r", "R"};
			16'h0014: key_chars = {"t", "T"};  16'h0015: key_chars = {"y", "Y"};
			16'h0016: key_chars = {"u", "U"};  16'h0017: key_chars = {"i", "I"};
			16'h0018: key_chars = {"o", "O"};  16'h0019: key_chars = {"p", "P"};
			16'h001A: key_chars = {"[", "{"};  16'h001B: key_chars = {"]", "}"};
			16'h002B: key_chars = {"\\", "|"};
			16'h001E: key_chars = {"a", "A"};  16'h001F: key_chars = {"s", "S"};
			16'h0020: key_chars = {"d", "D"};  16'h0021: key_chars = {"f", "F"};
			16'h0022: key_chars = {"g", "G"};  16'h0023: key_chars = {"h", "H"};
			16'h0024: key_chars = {"j", "J"};  16'h0025: key_chars = {"k", "K"};
			16'h0026: key_chars = {"l", "L"};  16'h0027: key_chars = {";", ":"};
			16'h0028: key_chars = {"'", "\""};
			16'h002C: key_chars = {"z", "Z"};  16'h002D: key_chars = {"x", "X"};
			16'h002E: key_chars = {"c", "C"};  16'h002F: key_chars = {"v", "V"};
			16'h0030: key_chars = {"b", "B"};  16'h0031: key_chars = {"n", "N"};
			16'h0032: key_chars = {"m", "M"};  16'h0033: key_chars = {",", "<"};
			16'h0034: key_chars = {".", ">"};  16'h0035: key_chars = {"/", "?"};
			default:  key_chars = 16'h0000;
		endcase
	endfunction

	// advances the checker's decoder state by one word and gives its result
	function automatic result_t decode_scan(input logic [7:0] scan, input logic err);
		result_t    r;
		logic [15:0] code;
		logic [15:0] chars;
		logic        upper;
		r.ev = EV_NONE;
		r.ch = 7'd0;
		// error words leave the state alone
		if (!err) begin
			if (scan == PREFIX_BYTE) begin
				prefix_held = 1'b1;
			end else begin
				code = prefix_held ? {8'hE0, scan} : {8'h00, scan};
				prefix_held = 1'b0;
				// modifiers first, so the key sees its own effect
				case (code)
					CODE_LSHIFT_MAKE, CODE_RSHIFT_MAKE:   mod_mask[MOD_SHIFT_BIT] = 1'b1;
					CODE_LSHIFT_BREAK, CODE_RSHIFT_BREAK: mod_mask[MOD_SHIFT_BIT] = 1'b0;
					CODE_CAPS_MAKE:                       mod_mask[MOD_CAPS_BIT] ^= 1'b1;
					CODE_CTRL_MAKE:                       mod_mask[MOD_CTRL_BIT] = 1'b1;
					CODE_CTRL_BREAK:                      mod_mask[MOD_CTRL_BIT] = 1'b0;
					CODE_ALT_MAKE, CODE_RALT_MAKE:        mod_mask[MOD_ALT_BIT] = 1'b1;
					CODE_ALT_BREAK, CODE_RALT_BREAK:      mod_mask[MOD_ALT_BIT] = 1'b0;
					default: ;
				endcase
				chars = key_chars(code);
				upper = mod_mask[MOD_CAPS_BIT] ^ mod_mask[MOD_SHIFT_BIT];
				if ((mod_mask[MOD_CTRL_BIT] || mod_mask[MOD_ALT_BIT])
				    && code == CODE_BACKSPACE)
					r.ev = EV_WORD_DELETE;
				else if (code == CODE_ESC_BREAK)
					r.ev = EV_EXIT;
				else if (code == CODE_SPACE)
					r.ev = EV_SPACE;
				else if (code == CODE_BACKSPACE)
					r.ev = EV_BACKSPACE;
				else if (code == CODE_ENTER)
					r.ev = EV_ENTER;
				else if (code == CODE_TAB)
					r.ev = EV_TAB;
				else if (chars != 16'h0000) begin
					r.ev = EV_CHAR;
					r.ch = upper ? chars[6:0] : chars[14:8];
				end
			end
		end
		r.mods = mod_mask;
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0t ns  mismatch: %s", $time, what);
		mismatches++;
	endtask

	task automatic put_word(input logic [7:0] scan, input logic err = 1'b0,
	                        input logic drain = 1'b0);
		scan_word_t w;
		w.scan = scan;
		w.err = err;
		w.drain = drain;
		scan_words.push_back(w);
	endtask

	// sender: one word per handshake, valid held until taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			rx_byte <= 8'h00;
			rx_error <= 1'b0;
		end else begin
			// word taken at this edge: predict it and move on
			if (in_valid && in_ready) begin
				expected_results.push_back(decode_scan(rx_byte, rx_error));
				scan_words.delete(0);
				words_sent++;
			end
			// free to present the next word (or to idle)
			if (!in_valid || in_ready) begin
				if (scan_words.size() != 0
				    && !(scan_words[0].drain && expected_results.size() != 0)
				    && $urandom_range(0, 99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					rx_byte <= scan_words[0].scan;
					rx_error <= scan_words[0].err;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: random back-pressure, every taken word checked in order
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("result word with nothing pending (event %0d)",
						event_code));
				end else begin
					if (event_code !== expected_results[0].ev)
						report_mismatch($sformatf("event_code got %0d want %0d",
							event_code, expected_results[0].ev));
					if (char_code !== expected_results[0].ch)
						report_mismatch($sformatf("char_code got %h want %h",
							char_code, expected_results[0].ch));
					if (modifiers !== expected_results[0].mods)
						report_mismatch($sformatf("modifiers got %b want %b",
							modifiers, expected_results[0].mods));
					expected_results.delete(0);
				end
			end
			out_ready <= ($urandom_range(0, 99) >= take_idle_pct);
		end
	end

	// watchdog: too long with no word moving on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("** keyboard_scancode_event_decoder: FAILED **");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		int total;
		int pick;
		logic [7:0] scan;

		// directed opening
		put_word(8'h00);                   // lowest byte, no key
		put_word(8'hFF);                   // highest byte, no key
		put_word(8'h1E);                   // 'a'
		put_word(8'h9E);                   // break of a table key gives nothing
		put_word(8'h2A);                   // left shift make
		put_word(8'h1E);                   // 'A'
		put_word(8'h02);                   // '!'
		put_word(8'hAA);                   // left shift break
		put_word(8'h3A);                   // caps on
		put_word(8'h0B);                   // caps alone shifts symbols too: ')'
		put_word(8'h36);                   // right shift with caps: back to lower
		put_word(8'h10);                   // 'q'
		put_word(8'hB6);
		put_word(8'h3A);                   // caps off
		put_word(8'h39);                   // space
		put_word(8'h0E);                   // backspace
		put_word(8'h1D);                   // ctrl held: word delete
		put_word(8'h0E);
		put_word(8'h9D);
		put_word(8'hE0);                   // right alt make, with an error word
		put_word(8'h2A, 1'b1);             // inside the prefix (dropped)
		put_word(8'h38);
		put_word(8'h0E);                   // alt held: word delete
		put_word(8'hE0);
		put_word(8'hB8);                   // right alt break
		put_word(8'h1C);                   // enter
		put_word(8'h0F);                   // tab
		put_word(8'h81);                   // escape break: exit
		put_word(8'hE0);                   // doubled prefix, then extended zero
		put_word(8'hE0);
		put_word(8'h00);
		put_word(8'hE0);                   // right ctrl is not a modifier
		put_word(8'h1D);
		put_word(8'h38);                   // left alt make / break
		put_word(8'hB8);

		// random stream, mostly well-formed key traffic
		total = scan_words.size() + RANDOM_WORDS;
		put_word(8'h1E, 1'b0, 1'b1);       // pause until the opening has drained
		while (scan_words.size() < total) begin
			pick = $urandom_range(0, 99);
			if (pick < 40)
				put_word(8'($urandom_range(8'h02, 8'h35)));
			else if (pick < 55)
				put_word(modifier_scans[$urandom_range(0, 8)]);
			else if (pick < 62) begin
				put_word(PREFIX_BYTE);
				put_word($urandom_range(0, 1) ? 8'h38 : 8'hB8);
			end else if (pick < 70)
				put_word(special_scans[$urandom_range(0, 4)]);
			else if (pick < 80) begin
				put_word(PREFIX_BYTE);
				put_word(8'($urandom_range(0, 255)));
			end else if (pick < 90)
				put_word(8'($urandom_range(0, 255)));
			else begin
				scan = 8'($urandom_range(0, 255));
				put_word(scan, 1'b1);
			end
			// now and then let everything drain before the next word
			if ($urandom_range(0, 159) == 0)
				scan_words[$].drain = 1'b1;
		end
		total = scan_words.size();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// idling pattern swaps at the thirds, last third runs flat out
		while (words_sent < total / 3)
			@(posedge clk);
		send_idle_pct = 73;
		take_idle_pct = 25;
		while (words_sent < 2 * total / 3)
			@(posedge clk);
		send_idle_pct = 0;
		take_idle_pct = 0;

		while (scan_words.size() != 0 || expected_results.size() != 0)
			@(posedge clk);
		// wait for any stray result word to show up
		repeat (8) @(posedge clk);

		if (mismatches == 0)
			$display("** keyboard_scancode_event_decoder: PASSED **");
		else
			$display("** keyboard_scancode_event_decoder: FAILED **");
		$finish;
	end

endmodule
